/* sv/bthp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bthp_pkg
// Shared types and defaults for the BER-TLV header parser.
// ----------------------------------------------------------------------------
package bthp_pkg;

  localparam int DefMaxTagBytes    = 3;
  localparam int DefMaxLenFldBytes = 3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [1:0]  tag_class;
    logic        constructed;
    logic [13:0] tag_number;
    logic [15:0] value_length;
    logic [2:0]  header_length;
  } hdr_item_t;

  // parser result toward the output register
  typedef struct packed {
    logic      valid;
    hdr_item_t item;
  } res_t;

endpackage

/* sv/bthp_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bthp_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface bthp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* sv/bthp_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bthp_in_stage
// Input register: holds one byte item until the parser consumes it.
// ----------------------------------------------------------------------------
module bthp_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  bthp_stream_if.sink        in_if,
  input  logic               step_i,
  output logic               valid_o,
  output bthp_pkg::in_item_t item_o
);
  import bthp_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign in_if.ready = !valid_q || step_i;
  assign load        = in_if.valid && in_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (step_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_if.payload;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* sv/bthp_parse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bthp_parse
// Header state machine: one byte per step, result formed in the same cycle.
// ----------------------------------------------------------------------------
module bthp_parse #(
  parameter int MAX_TAG_BYTES          = bthp_pkg::DefMaxTagBytes,
  parameter int MAX_LENGTH_FIELD_BYTES = bthp_pkg::DefMaxLenFldBytes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  bthp_pkg::in_item_t item_i,
  output bthp_pkg::res_t     res_o
);
  import bthp_pkg::*;

  localparam int TagCntW = $clog2(MAX_TAG_BYTES);
  localparam int LenCntW = $clog2(MAX_LENGTH_FIELD_BYTES);

  typedef enum logic [5:0] {
    PH_TAG0 = 6'b000001,
    PH_TAGN = 6'b000010,
    PH_LEN0 = 6'b000100,
    PH_LENN = 6'b001000,
    PH_SKIP = 6'b010000,
    PH_ERR  = 6'b100000
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [1:0]         class_q, class_d;
  logic               cons_q, cons_d;
  logic [13:0]        number_q, number_d;
  logic [TagCntW-1:0] tag_seen_q, tag_seen_d;
  logic [15:0]        length_q, length_d;
  logic [LenCntW-1:0] len_left_q, len_left_d;
  logic [2:0]         hcount_q, hcount_d;
  logic [15:0]        skip_q, skip_d;

  logic [7:0] b;
  logic [6:0] cnt;
  logic       emit;
  status_e    status;

  assign b   = item_i.data_byte;
  assign cnt = b[6:0];

  always_comb begin
    phase_d    = phase_q;
    class_d    = class_q;
    cons_d     = cons_q;
    number_d   = number_q;
    tag_seen_d = tag_seen_q;
    length_d   = length_q;
    len_left_d = len_left_q;
    hcount_d   = hcount_q;
    skip_d     = skip_q;
    emit       = 1'b0;
    status     = ST_OK;

    case (phase_q)
      PH_TAGN: begin
        hcount_d   = hcount_q + 3'd1;
        tag_seen_d = tag_seen_q + TagCntW'(1);
        if (number_q[13:7] != 7'd0) begin
          // next 7 bits would overflow the tag number
          emit    = 1'b1;
          status  = ST_MALFORMED;
          phase_d = PH_ERR;
        end else begin
          number_d = {number_q[6:0], b[6:0]};
          if (!b[7]) begin
            phase_d = PH_LEN0;
          end else if (({1'b0, tag_seen_d} + (TagCntW+1)'(1))
                       >= (TagCntW+1)'(MAX_TAG_BYTES)) begin
            emit    = 1'b1;
            status  = ST_MALFORMED;
            phase_d = PH_ERR;
          end
        end
      end
      PH_LEN0: begin
        hcount_d = hcount_q + 3'd1;
        length_d = 16'd0;
        if (!b[7]) begin
          length_d = {9'd0, b[6:0]};
          emit     = 1'b1;
          skip_d   = length_d;
          phase_d  = (length_d != 16'd0) ? PH_SKIP : PH_TAG0;
        end else if (cnt == 7'd0 || cnt == 7'd127 ||
                     ({1'b0, cnt} + 8'd1) > 8'(MAX_LENGTH_FIELD_BYTES)) begin
          // indefinite, reserved or too many length bytes
          emit    = 1'b1;
          status  = ST_MALFORMED;
          phase_d = PH_ERR;
        end else begin
          len_left_d = cnt[LenCntW-1:0];
          phase_d    = PH_LENN;
        end
      end
      PH_LENN: begin
        hcount_d = hcount_q + 3'd1;
        if (length_q[15:8] != 8'd0) begin
          emit    = 1'b1;
          status  = ST_MALFORMED;
          phase_d = PH_ERR;
        end else begin
          length_d = {length_q[7:0], b};
          if (len_left_q != '0) begin
            len_left_d = len_left_q - LenCntW'(1);
          end
          if (len_left_d == '0) begin
            emit    = 1'b1;
            skip_d  = length_d;
            phase_d = (length_d != 16'd0) ? PH_SKIP : PH_TAG0;
          end
        end
      end
      PH_SKIP: begin
        if (skip_q != 16'd0) begin
          skip_d = skip_q - 16'd1;
        end
        if (skip_d == 16'd0) begin
          phase_d = PH_TAG0;
        end
      end
      PH_ERR: begin
        // drop bytes until buffer end
      end
      default: begin
        hcount_d   = 3'd1;
        class_d    = b[7:6];
        cons_d     = b[5];
        tag_seen_d = '0;
        length_d   = 16'd0;
        len_left_d = '0;
        if (b[4:0] == 5'h1F) begin
          number_d = 14'd0;
          phase_d  = PH_TAGN;
        end else begin
          number_d = {9'd0, b[4:0]};
          phase_d  = PH_LEN0;
        end
      end
    endcase

    if (item_i.end_of_buffer && !emit &&
        (phase_d == PH_TAGN || phase_d == PH_LEN0 || phase_d == PH_LENN)) begin
      emit   = 1'b1;
      status = ST_TRUNCATED;
    end

    // result always shows the updated header fields
    res_o.valid              = emit;
    res_o.item.status        = status;
    res_o.item.tag_class     = class_d;
    res_o.item.constructed   = cons_d;
    res_o.item.tag_number    = number_d;
    res_o.item.value_length  = length_d;
    res_o.item.header_length = hcount_d;

    if (item_i.end_of_buffer) begin
      phase_d    = PH_TAG0;
      class_d    = 2'd0;
      cons_d     = 1'b0;
      number_d   = 14'd0;
      tag_seen_d = '0;
      length_d   = 16'd0;
      len_left_d = '0;
      hcount_d   = 3'd0;
      skip_d     = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_TAG0;
      class_q    <= 2'd0;
      cons_q     <= 1'b0;
      number_q   <= 14'd0;
      tag_seen_q <= '0;
      length_q   <= 16'd0;
      len_left_q <= '0;
      hcount_q   <= 3'd0;
      skip_q     <= 16'd0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      class_q    <= class_d;
      cons_q     <= cons_d;
      number_q   <= number_d;
      tag_seen_q <= tag_seen_d;
      length_q   <= length_d;
      len_left_q <= len_left_d;
      hcount_q   <= hcount_d;
      skip_q     <= skip_d;
    end
  end

  a_eob_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.end_of_buffer |=> phase_q == PH_TAG0 && hcount_q == 3'd0)
    else $error("state not cleared after buffer end");

  a_err_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ERR || phase_q == PH_SKIP |-> !res_o.valid)
    else $error("result raised while skipping or in error");

  a_ok_from_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.item.status == ST_OK |-> phase_q == PH_LEN0 || phase_q == PH_LENN)
    else $error("good header outside length phase");

endmodule

/* sv/bthp_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bthp_out_stage
// Result register: holds one header item until the sink takes it.
// ----------------------------------------------------------------------------
module bthp_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  bthp_pkg::res_t res_i,
  output logic           free_o,
  bthp_stream_if.source  out_if
);
  import bthp_pkg::*;

  logic      valid_q, valid_d;
  hdr_item_t item_q;
  logic      load;

  assign free_o = !valid_q || out_if.ready;
  assign load   = step_i && res_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_if.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= res_i.item;
    end
  end

  assign out_if.valid   = valid_q;
  assign out_if.payload = item_q;

endmodule

/* sv/ber_tlv_header_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_tlv_header_parser_unit
// BER-TLV header parser: bytes in, one item per completed or failed header out.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                   handshake
//  -------  ---  ----------------------------------------  ------------
//  byte_i   in   data_byte, end_of_buffer                  valid/ready
//  hdr_o    out  status, tag_class, constructed,           valid/ready
//                tag_number, value_length, header_length
//
//  One byte item per cycle while the parser is not stalled; a byte is held in
//  the input register until the parser steps on it, and a header item that
//  byte ends is registered and valid on hdr_o from the next edge.
//  The rate is set by the single-step header state machine in bthp_parse.
//  rst_ni (async, active low) returns the parser to the first tag byte and
//  empties both registers; no clearing pass.
//  A result held on hdr_o while the sink is not ready stalls the parser for
//  any byte; byte_i.ready drops once the input register is full and blocked.
//
module ber_tlv_header_parser_unit #(
  parameter int MAX_TAG_BYTES          = bthp_pkg::DefMaxTagBytes,
  parameter int MAX_LENGTH_FIELD_BYTES = bthp_pkg::DefMaxLenFldBytes
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bthp_stream_if.sink   byte_i,
  bthp_stream_if.source hdr_o
);
  import bthp_pkg::*;

  logic     in_valid;
  in_item_t in_item;
  res_t     res;
  logic     out_free;
  logic     step;

  // parser consumes the held byte when the result register can take a result
  assign step = in_valid && out_free;

  bthp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (byte_i),
    .step_i  (step),
    .valid_o (in_valid),
    .item_o  (in_item)
  );

  bthp_parse #(
    .MAX_TAG_BYTES          (MAX_TAG_BYTES),
    .MAX_LENGTH_FIELD_BYTES (MAX_LENGTH_FIELD_BYTES)
  ) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item),
    .res_o  (res)
  );

  bthp_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .res_i  (res),
    .free_o (out_free),
    .out_if (hdr_o)
  );

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_o.valid && !hdr_o.ready |-> !step)
    else $error("parser stepped while result held");

endmodule
